>>> rtl/mva_pkg.sv
// shared types, constants and helper functions for the msi vector allocator
`timescale 1ns / 1ps
`default_nettype none

package mva_pkg;

    // field widths
    localparam int OPC_W  = 3;
    localparam int ID_W   = 8;
    localparam int HART_W = 32;
    localparam int TGT_W  = 5;
    localparam int ADDR_W = 48;
    localparam int ST_W   = 2;
    localparam int CNT_W  = 6;
    localparam int CFG_IW = 2;

    // identity space
    localparam int MAX_ID       = 255;
    localparam int FIRST_MSI_ID = 64;
    localparam int MAX_HARTS    = 32;
    localparam int PAGE_SHIFT   = 12;
    localparam int DEPTH        = MAX_ID + 1;

    // used-bit scan geometry: one 32-id word per cycle
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int NUM_WORDS = (MAX_ID + WORD_BITS) / WORD_BITS;
    localparam int WORD_W    = $clog2(NUM_WORDS);
    localparam int STEP_W    = $clog2(NUM_WORDS + 1);
    localparam int SRCH_W    = NUM_WORDS * WORD_BITS;

    localparam logic [ADDR_W-1:0] MSG_BASE_RST = 48'h0000_2800_0000;

    // opcodes
    localparam logic [OPC_W-1:0] OP_ALLOC    = 3'd0;
    localparam logic [OPC_W-1:0] OP_RETARGET = 3'd1;
    localparam logic [OPC_W-1:0] OP_ENABLE   = 3'd2;
    localparam logic [OPC_W-1:0] OP_DISABLE  = 3'd3;
    localparam logic [OPC_W-1:0] OP_AFFINITY = 3'd4;

    // status codes
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_INVAL  = 2'd1;
    localparam logic [ST_W-1:0] ST_NOSPC  = 2'd2;
    localparam logic [ST_W-1:0] ST_NOTSUP = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_HART_COUNT = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_LOCAL_CPU  = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_MSG_BASE   = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_BACKEND_ON = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SRCH,
        S_WR
    } t_state;

    // one table entry
    typedef struct packed {
        logic              enabled;
        logic              file_en;
        logic [HART_W-1:0] affinity;
    } t_entry;

    localparam t_entry ENTRY_RST = '{enabled: 1'b0, file_en: 1'b0, affinity: 32'd1};

    // search unit result
    typedef struct packed {
        logic            done;
        logic            found;
        logic [ID_W-1:0] id;
    } t_srch_res;

    function automatic logic [TGT_W-1:0] lowest_bit(input logic [HART_W-1:0] m);
        logic [TGT_W-1:0] pos;
        pos = '0;
        for (int i = HART_W - 1; i >= 0; i--) begin
            if (m[i]) pos = TGT_W'(i);
        end
        return pos;
    endfunction

    // low n bits set, n = hart count clamped to 1..MAX_HARTS
    function automatic logic [HART_W-1:0] valid_mask(input logic [CNT_W-1:0] cnt);
        logic [HART_W-1:0] vm;
        if (cnt == '0) begin
            vm = HART_W'(1);
        end else if (cnt >= CNT_W'(MAX_HARTS)) begin
            vm = '1;
        end else begin
            vm = (HART_W'(1) << cnt) - HART_W'(1);
        end
        return vm;
    endfunction

endpackage

`default_nettype wire

>>> rtl/mva_table.sv
// per-identity table memory with valid bits standing in for the reset value
`timescale 1ns / 1ps
`default_nettype none

module mva_table (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_rd_en,
    input  logic [mva_pkg::ID_W-1:0]         i_rd_addr,
    input  logic                             i_wr_en,
    input  logic [mva_pkg::ID_W-1:0]         i_wr_addr,
    input  mva_pkg::t_entry                  i_wr_data,
    output mva_pkg::t_entry                  o_rd_data
);
    import mva_pkg::*;

    t_entry             r_mem [DEPTH];
    logic [DEPTH-1:0]   r_vld;
    t_entry             r_rdata;
    logic               r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    // never-written entries read as their reset contents
    assign o_rd_data = r_rd_vld ? r_rdata : ENTRY_RST;

endmodule

`default_nettype wire

>>> rtl/mva_search.sv
// used-bit vector and next-fit free identity scan, one 32-id word per cycle
`timescale 1ns / 1ps
`default_nettype none

module mva_search (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mva_pkg::ID_W-1:0]    i_rover,
    input  logic                        i_set_en,
    input  logic [mva_pkg::ID_W-1:0]    i_set_id,
    input  logic [mva_pkg::ID_W-1:0]    i_look_id,
    output logic                        o_look_used,
    output mva_pkg::t_srch_res          o_res
);
    import mva_pkg::*;

    logic [SRCH_W-1:0]     r_used;
    logic                  r_busy;
    logic [WORD_W-1:0]     r_word;
    logic [BIT_W-1:0]      r_lo;
    logic [STEP_W-1:0]     r_step;

    logic [WORD_BITS-1:0]  word_used;
    logic [WORD_BITS-1:0]  cand;
    logic                  any_free;
    logic [ID_W-1:0]       bit_id;

    assign word_used = r_used[r_word * WORD_BITS +: WORD_BITS];

    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            bit_id  = {r_word, BIT_W'(b)};
            cand[b] = !word_used[b]
                      && (bit_id >= ID_W'(FIRST_MSI_ID))
                      && (bit_id <= ID_W'(MAX_ID));
            // first word from the rover upwards, last pass below it
            if (r_step == '0 && BIT_W'(b) < r_lo) begin
                cand[b] = 1'b0;
            end
            if (r_step == STEP_W'(NUM_WORDS) && BIT_W'(b) >= r_lo) begin
                cand[b] = 1'b0;
            end
        end
    end

    assign any_free    = |cand;
    assign o_res.done  = r_busy && (any_free || r_step == STEP_W'(NUM_WORDS));
    assign o_res.found = r_busy && any_free;
    assign o_res.id    = {r_word, lowest_bit(cand)};
    assign o_look_used = r_used[i_look_id];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_busy <= 1'b0;
        end else begin
            if (i_set_en) begin
                r_used[i_set_id] <= 1'b1;
            end
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (o_res.done) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_word <= i_rover[ID_W-1 -: WORD_W];
            r_lo   <= i_rover[BIT_W-1:0];
            r_step <= '0;
        end else if (r_busy && !o_res.done) begin
            r_step <= r_step + STEP_W'(1);
            r_word <= (r_word == WORD_W'(NUM_WORDS - 1)) ? '0 : r_word + WORD_W'(1);
        end
    end

`ifndef SYNTHESIS
    a_found_is_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.found |-> !r_used[o_res.id]
                        && o_res.id >= ID_W'(FIRST_MSI_ID) && o_res.id <= ID_W'(MAX_ID))
        else $error("search returned a used or out-of-range identity");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("search started while busy");
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_step <= STEP_W'(NUM_WORDS))
        else $error("search ran past the wrap word");
`endif

endmodule

`default_nettype wire

>>> rtl/msi_vector_allocator.sv
// top level of the msi vector allocator: control, configuration and result register
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------------------
//  in      | to block  | i_in_valid / o_in_stall    | i_opcode, i_irq_id, i_cpu_mask
//  out     | from block| o_out_valid / i_out_stall  | o_status, o_result_id, o_msg_address,
//          |           |                            | o_msg_data, o_file_enable
//  cfg     | to block  | i_cfg_we                   | i_cfg_index, i_cfg_data
//
//  retarget, enable, disable, set affinity and refused operations read the table entry
//  in the accept cycle; write-back writes the updated entry once the output register is
//  free, but not for invalid requests or a disabled backend; allocate first scans the used
//  bits, one 32-id word per cycle, up to 9 words counting the wrap back to the rover's own word
//  one transfer is in the engine at a time; a finished result waits in the output
//  register while the next transfer is accepted, and only blocks write-back when full
//  reset is synchronous; the table needs no clearing pass, valid bits cover it
`timescale 1ns / 1ps
`default_nettype none

module msi_vector_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [mva_pkg::OPC_W-1:0]       i_opcode,
    input  logic [mva_pkg::ID_W-1:0]        i_irq_id,
    input  logic [mva_pkg::HART_W-1:0]      i_cpu_mask,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [mva_pkg::ST_W-1:0]        o_status,
    output logic [mva_pkg::ID_W-1:0]        o_result_id,
    output logic [mva_pkg::ADDR_W-1:0]      o_msg_address,
    output logic [mva_pkg::ID_W-1:0]        o_msg_data,
    output logic                            o_file_enable,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [mva_pkg::CFG_IW-1:0]      i_cfg_index,
    input  logic [mva_pkg::ADDR_W-1:0]      i_cfg_data
);
    import mva_pkg::*;

    // configuration registers
    logic [CNT_W-1:0]   r_hart_count;
    logic [TGT_W-1:0]   r_local_cpu;
    logic [ADDR_W-1:0]  r_msg_base;
    logic               r_backend;

    // control
    t_state             r_state;
    t_state             n_state;
    logic [ID_W-1:0]    r_rover;

    // captured request
    logic [OPC_W-1:0]   r_op;
    logic [ID_W-1:0]    r_id;
    logic [HART_W-1:0]  r_m;
    logic [TGT_W-1:0]   r_tgt;
    logic               r_used_q;
    logic               r_found;
    logic [ID_W-1:0]    r_cur;

    // result register
    logic               r_out_valid;
    logic [ST_W-1:0]    r_status;
    logic [ID_W-1:0]    r_rid;
    logic [ADDR_W-1:0]  r_addr;
    logic [ID_W-1:0]    r_data;
    logic               r_fe;

    // next result values
    logic [ST_W-1:0]    n_status;
    logic [ID_W-1:0]    n_rid;
    logic [ADDR_W-1:0]  n_addr;
    logic [ID_W-1:0]    n_data;
    logic               n_fe;

    logic               in_acc;
    logic               srch_start;
    logic               rd_en;
    logic [ID_W-1:0]    rd_addr;
    logic               out_free;
    logic               out_load;
    logic               upd;
    logic               set_used;
    logic [HART_W-1:0]  vm;
    logic [HART_W-1:0]  in_m;
    logic [HART_W-1:0]  aff_cand;
    logic [HART_W-1:0]  aff_cut;
    logic [TGT_W-1:0]   tgt;
    logic               want_msg;
    logic               id_ok;
    logic               m_ok;
    t_entry             cur_e;
    t_entry             new_e;
    t_srch_res          srch;
    logic               look_used;

    assign vm   = valid_mask(r_hart_count);
    assign in_m = i_cpu_mask & vm;

    assign out_free = !r_out_valid || !i_out_stall;

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hart_count <= CNT_W'(1);
            r_local_cpu  <= '0;
            r_msg_base   <= MSG_BASE_RST;
            r_backend    <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HART_COUNT: r_hart_count <= i_cfg_data[CNT_W-1:0];
                CFG_LOCAL_CPU:  r_local_cpu  <= i_cfg_data[TGT_W-1:0];
                CFG_MSG_BASE:   r_msg_base   <= i_cfg_data;
                CFG_BACKEND_ON: r_backend    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and table read control
    always_comb begin
        n_state    = r_state;
        in_acc     = 1'b0;
        srch_start = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = i_irq_id;
        out_load   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    in_acc = 1'b1;
                    rd_en  = 1'b1;
                    if (i_opcode == OP_ALLOC && r_backend) begin
                        srch_start = 1'b1;
                        n_state    = S_SRCH;
                    end else begin
                        n_state = S_WR;
                    end
                end
            end
            S_SRCH: begin
                // read the found entry as the scan finishes
                if (srch.done) begin
                    if (srch.found) begin
                        rd_en   = 1'b1;
                        rd_addr = srch.id;
                    end
                    n_state = S_WR;
                end
            end
            S_WR: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    // capture the request; mask cut and target picked here to keep write-back short
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op     <= i_opcode;
            r_id     <= i_irq_id;
            r_m      <= in_m;
            r_tgt    <= lowest_bit(in_m);
            r_used_q <= look_used;
            r_found  <= 1'b0;
        end else if (r_state == S_SRCH && srch.found) begin
            r_found <= 1'b1;
            r_cur   <= srch.id;
        end
    end

    // read-modify-write of the table entry
    always_comb begin
        id_ok    = (r_id != '0) && (r_id <= ID_W'(MAX_ID));
        m_ok     = (r_m != '0);
        n_status = ST_OK;
        n_rid    = r_id;
        upd      = 1'b0;
        set_used = 1'b0;
        want_msg = 1'b0;
        tgt      = '0;
        new_e    = cur_e;
        aff_cand = cur_e.affinity;

        if (r_op > OP_AFFINITY) begin
            n_status = ST_INVAL;
        end else if (!r_backend) begin
            n_status = ST_NOTSUP;
            if (r_op == OP_ALLOC) n_rid = '0;
        end else begin
            case (r_op) inside
                OP_ALLOC: begin
                    if (!r_found) begin
                        n_status = ST_NOSPC;
                        n_rid    = '0;
                    end else begin
                        n_rid         = r_cur;
                        upd           = 1'b1;
                        set_used      = 1'b1;
                        new_e.enabled = 1'b1;
                        aff_cand      = HART_W'(1);
                        want_msg      = 1'b1;
                    end
                end
                OP_RETARGET: begin
                    if (!m_ok || !id_ok || !r_used_q) begin
                        n_status = ST_INVAL;
                    end else begin
                        upd      = 1'b1;
                        aff_cand = r_m;
                        tgt      = r_tgt;
                        want_msg = 1'b1;
                    end
                end
                OP_ENABLE, OP_DISABLE: begin
                    if (!id_ok) begin
                        n_status = ST_INVAL;
                    end else begin
                        upd           = 1'b1;
                        new_e.enabled = (r_op == OP_ENABLE);
                    end
                end
                default: begin
                    if (!id_ok || !m_ok) begin
                        n_status = ST_INVAL;
                    end else begin
                        upd      = 1'b1;
                        aff_cand = r_m;
                    end
                end
            endcase
        end

        // affinity renormalised on every update, empty becomes hart 0
        aff_cut        = aff_cand & vm;
        new_e.affinity = (aff_cut == '0) ? HART_W'(1) : aff_cut;
        // file enable only tracked when the local hart is hart 0
        if (r_local_cpu == '0) begin
            new_e.file_en = new_e.enabled & new_e.affinity[0];
        end

        // message goes to the lowest target only if it is this hart
        if (want_msg && tgt != r_local_cpu) begin
            n_status = ST_NOTSUP;
        end
        if (want_msg && n_status == ST_OK) begin
            n_addr = r_msg_base + (ADDR_W'(tgt) << PAGE_SHIFT);
            n_data = n_rid;
        end else begin
            n_addr = '0;
            n_data = '0;
        end

        if (upd) begin
            n_fe = new_e.file_en;
        end else begin
            n_fe = (n_rid != '0) && (n_rid <= ID_W'(MAX_ID)) && cur_e.file_en;
        end
    end

    // rover moves past each identity handed out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rover <= ID_W'(FIRST_MSI_ID);
        end else if (out_load && set_used) begin
            r_rover <= (r_cur >= ID_W'(MAX_ID)) ? ID_W'(FIRST_MSI_ID) : r_cur + ID_W'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_status <= n_status;
            r_rid    <= n_rid;
            r_addr   <= n_addr;
            r_data   <= n_data;
            r_fe     <= n_fe;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_result_id   = r_rid;
    assign o_msg_address = r_addr;
    assign o_msg_data    = r_data;
    assign o_file_enable = r_fe;

    mva_search u_search (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (srch_start),
        .i_rover     (r_rover),
        .i_set_en    (out_load && set_used),
        .i_set_id    (r_cur),
        .i_look_id   (i_irq_id),
        .o_look_used (look_used),
        .o_res       (srch)
    );

    mva_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr_en   (out_load && upd),
        .i_wr_addr (n_rid),
        .i_wr_data (new_e),
        .o_rd_data (cur_e)
    );

`ifndef SYNTHESIS
    a_wr_in_wr_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && upd) |-> r_state == S_WR)
        else $error("table written outside write-back");
    a_rover_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rover >= ID_W'(FIRST_MSI_ID) && r_rover <= ID_W'(MAX_ID))
        else $error("rover out of the msi identity range");
    a_result_from_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_WR))
        else $error("result appeared without a write-back cycle");
    a_search_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        srch_start |-> r_state == S_IDLE && r_backend)
        else $error("scan started outside an accepted allocate");
`endif

endmodule

`default_nettype wire
